@@ sv/box_motion_change_detector_core_macros.svh @@
// Assertion helpers for the checker file.
`ifndef BOX_MOTION_CHANGE_DETECTOR_CORE_MACROS_SVH
`define BOX_MOTION_CHANGE_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BMCD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmcd assertion failed");

// Next-cycle implication, disabled while reset is low.
`define BMCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmcd assertion failed");

`endif

@@ sv/bmcd_pkg.sv @@
package bmcd_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_THR     = 2'd2;

  // Register widths and reset values
  localparam int OVERLAP_THR_W = 17;
  localparam int RATIO_THR_W   = 16;
  localparam int RATIO_SQ_W    = 2 * RATIO_THR_W;

  localparam logic                     MOTION_ENABLE_RST = 1'b1;
  localparam logic [OVERLAP_THR_W-1:0] OVERLAP_THR_RST   = 17'd32768;
  localparam logic [RATIO_THR_W-1:0]   RATIO_THR_RST     = 16'd410;

  // Fixed-point scaling: IoU in Q1.16, squared Q4.12 ratio carries 2^24, doubled
  // centers carry 2^2, leaving 2^22 on the shift side.
  localparam int OVERLAP_FRAC = 16;
  localparam int SHIFT_SCALE  = 22;

endpackage

@@ sv/box_motion_change_detector_core.sv @@
// Box motion change detector. Each request carries a previous and a current box
// (left, top, width, height in pixels); one result comes back per request with
// overlap_low (IoU below the Q1.16 overlap threshold, a zero union counting as
// IoU zero), center_shifted (IoU passes and center shift over the previous
// diagonal reaches the Q4.12 ratio threshold, never for a zero diagonal) and
// motion_detected (their OR); all three read zero while motion_enable is clear.
// The datapath is a five-stage pipeline: edge clipping and center differences,
// products, sums, split threshold products, then the final compares into the
// output register. One request is accepted every cycle while in_stall is low;
// a result held under out_stall freezes every stage at once, so in_stall is
// high exactly while a result waits in the output register and out_stall is
// high. The configuration port is always ready; write it only while no
// request is in flight.
module box_motion_change_detector_core #(
  parameter int COORD_BITS = 14
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [COORD_BITS-1:0]            in_prev_left,
  input  logic [COORD_BITS-1:0]            in_prev_top,
  input  logic [COORD_BITS-1:0]            in_prev_width,
  input  logic [COORD_BITS-1:0]            in_prev_height,
  input  logic [COORD_BITS-1:0]            in_cur_left,
  input  logic [COORD_BITS-1:0]            in_cur_top,
  input  logic [COORD_BITS-1:0]            in_cur_width,
  input  logic [COORD_BITS-1:0]            in_cur_height,

  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_motion_detected,
  output logic                             out_overlap_low,
  output logic                             out_center_shifted,

  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bmcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bmcd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int N    = COORD_BITS;
  localparam int EW   = N + 1;        // right / bottom edge
  localparam int DXW  = N + 2;        // doubled center
  localparam int AW   = 2 * N;        // areas and squared sides
  localparam int SQW  = 2 * DXW;      // squared center difference
  localparam int SW   = SQW + 1;      // sum of squared differences
  localparam int UW   = AW + 1;       // union and diagonal squared
  localparam int LOW  = (UW + 1) / 2; // low part of a split operand
  localparam int HIW  = UW - LOW;     // high part of a split operand
  localparam int THW  = bmcd_pkg::OVERLAP_THR_W;
  localparam int RW   = bmcd_pkg::RATIO_THR_W;
  localparam int R2W  = bmcd_pkg::RATIO_SQ_W;
  localparam int OVW  = THW + UW;
  localparam int SHW  = R2W + UW;

  // ---------------------------------------------------------------- config
  logic           motion_enable_r;
  logic [THW-1:0] overlap_thr_r;
  logic [RW-1:0]  ratio_thr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motion_enable_r <= bmcd_pkg::MOTION_ENABLE_RST;
      overlap_thr_r   <= bmcd_pkg::OVERLAP_THR_RST;
      ratio_thr_r     <= bmcd_pkg::RATIO_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bmcd_pkg::CFG_MOTION_ENABLE: motion_enable_r <= cfg_data[0];
        bmcd_pkg::CFG_OVERLAP_THR:   overlap_thr_r   <= cfg_data[THW-1:0];
        bmcd_pkg::CFG_RATIO_THR:     ratio_thr_r     <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  logic adv;
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;

  // Advance every stage together unless a finished result is held.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic [EW-1:0]  p_right, c_right, p_bottom, c_bottom;
  logic [N-1:0]   lo_x, lo_y;
  logic [EW-1:0]  hi_x, hi_y, span_x, span_y;
  logic [N-1:0]   iw_nxt, ih_nxt;
  logic [DXW-1:0] p_cx, c_cx, p_cy, c_cy, dx_nxt, dy_nxt;

  always_comb begin
    p_right  = EW'(in_prev_left) + EW'(in_prev_width);
    c_right  = EW'(in_cur_left)  + EW'(in_cur_width);
    p_bottom = EW'(in_prev_top)  + EW'(in_prev_height);
    c_bottom = EW'(in_cur_top)   + EW'(in_cur_height);

    lo_x = (in_prev_left > in_cur_left) ? in_prev_left : in_cur_left;
    lo_y = (in_prev_top  > in_cur_top)  ? in_prev_top  : in_cur_top;
    hi_x = (p_right  < c_right)  ? p_right  : c_right;
    hi_y = (p_bottom < c_bottom) ? p_bottom : c_bottom;

    // Clipped span never exceeds the narrower box, so it fits N bits.
    span_x = hi_x - EW'(lo_x);
    span_y = hi_y - EW'(lo_y);
    iw_nxt = (hi_x > EW'(lo_x)) ? span_x[N-1:0] : '0;
    ih_nxt = (hi_y > EW'(lo_y)) ? span_y[N-1:0] : '0;

    // Doubled centers keep everything integer.
    p_cx = DXW'({in_prev_left, 1'b0}) + DXW'(in_prev_width);
    c_cx = DXW'({in_cur_left,  1'b0}) + DXW'(in_cur_width);
    p_cy = DXW'({in_prev_top,  1'b0}) + DXW'(in_prev_height);
    c_cy = DXW'({in_cur_top,   1'b0}) + DXW'(in_cur_height);
    dx_nxt = (c_cx > p_cx) ? c_cx - p_cx : p_cx - c_cx;
    dy_nxt = (c_cy > p_cy) ? c_cy - p_cy : p_cy - c_cy;
  end

  logic [N-1:0]   s1_iw_r, s1_ih_r, s1_pw_r, s1_ph_r, s1_cw_r, s1_ch_r;
  logic [DXW-1:0] s1_dx_r, s1_dy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_iw_r <= iw_nxt;
      s1_ih_r <= ih_nxt;
      s1_dx_r <= dx_nxt;
      s1_dy_r <= dy_nxt;
      s1_pw_r <= in_prev_width;
      s1_ph_r <= in_prev_height;
      s1_cw_r <= in_cur_width;
      s1_ch_r <= in_cur_height;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic [AW-1:0]  s2_inter_r, s2_parea_r, s2_carea_r, s2_pw2_r, s2_ph2_r;
  logic [SQW-1:0] s2_dx2_r, s2_dy2_r;
  logic [R2W-1:0] s2_r2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_inter_r <= s1_iw_r * s1_ih_r;
      s2_parea_r <= s1_pw_r * s1_ph_r;
      s2_carea_r <= s1_cw_r * s1_ch_r;
      s2_pw2_r   <= s1_pw_r * s1_pw_r;
      s2_ph2_r   <= s1_ph_r * s1_ph_r;
      s2_dx2_r   <= s1_dx_r * s1_dx_r;
      s2_dy2_r   <= s1_dy_r * s1_dy_r;
      s2_r2_r    <= ratio_thr_r * ratio_thr_r;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic [AW-1:0]  s3_inter_r;
  logic [UW-1:0]  s3_union_r, s3_diag_r;
  logic [SW-1:0]  s3_sum_r;
  logic [R2W-1:0] s3_r2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_inter_r <= s2_inter_r;
      // Intersection never exceeds either area, so this cannot wrap.
      s3_union_r <= UW'(s2_parea_r) + UW'(s2_carea_r) - UW'(s2_inter_r);
      s3_diag_r  <= UW'(s2_pw2_r) + UW'(s2_ph2_r);
      s3_sum_r   <= SW'(s2_dx2_r) + SW'(s2_dy2_r);
      s3_r2_r    <= s2_r2_r;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Threshold products are split in two halves to keep each multiplier narrow.
  logic [THW+LOW-1:0] s4_ov_lo_r;
  logic [THW+HIW-1:0] s4_ov_hi_r;
  logic [R2W+LOW-1:0] s4_sh_lo_r;
  logic [R2W+HIW-1:0] s4_sh_hi_r;
  logic [AW-1:0]      s4_inter_r;
  logic [SW-1:0]      s4_sum_r;
  logic               s4_union_zero_r, s4_diag_zero_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ov_lo_r      <= overlap_thr_r * s3_union_r[LOW-1:0];
      s4_ov_hi_r      <= overlap_thr_r * s3_union_r[UW-1:LOW];
      s4_sh_lo_r      <= s3_r2_r * s3_diag_r[LOW-1:0];
      s4_sh_hi_r      <= s3_r2_r * s3_diag_r[UW-1:LOW];
      s4_inter_r      <= s3_inter_r;
      s4_sum_r        <= s3_sum_r;
      s4_union_zero_r <= (s3_union_r == '0);
      s4_diag_zero_r  <= (s3_diag_r == '0);
    end
  end

  // ---------------------------------------------------------------- stage 5
  logic [OVW-1:0] ov_lhs, ov_rhs;
  logic [SHW-1:0] sh_lhs, sh_rhs;
  logic           low_nxt, shifted_nxt;

  always_comb begin
    ov_lhs = OVW'(s4_inter_r) << bmcd_pkg::OVERLAP_FRAC;
    ov_rhs = (OVW'(s4_ov_hi_r) << LOW) + OVW'(s4_ov_lo_r);
    sh_lhs = SHW'(s4_sum_r) << bmcd_pkg::SHIFT_SCALE;
    sh_rhs = (SHW'(s4_sh_hi_r) << LOW) + SHW'(s4_sh_lo_r);

    // A zero union counts as IoU zero.
    if (s4_union_zero_r) begin
      low_nxt = motion_enable_r && (overlap_thr_r != '0);
    end else begin
      low_nxt = motion_enable_r && (ov_lhs < ov_rhs);
    end
    shifted_nxt = motion_enable_r && !low_nxt && !s4_diag_zero_r && (sh_lhs >= sh_rhs);
  end

  logic out_low_r, out_shifted_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_low_r     <= low_nxt;
      out_shifted_r <= shifted_nxt;
    end
  end

  assign out_overlap_low     = out_low_r;
  assign out_center_shifted  = out_shifted_r;
  assign out_motion_detected = out_low_r | out_shifted_r;

endmodule

@@ sv/bmcd_checker.sv @@
`include "box_motion_change_detector_core_macros.svh"

module bmcd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_motion_detected,
  input logic out_overlap_low,
  input logic out_center_shifted
);

  // Motion is exactly the OR of the two tests.
  `BMCD_ASSERT_SAME(a_motion_or, clk, rst_n, out_valid,
                    out_motion_detected == (out_overlap_low | out_center_shifted))

  // The shift test only runs when the overlap test passes.
  `BMCD_ASSERT_SAME(a_tests_exclusive, clk, rst_n, out_valid,
                    !(out_overlap_low && out_center_shifted))

  // An empty output register never pushes back on the input.
  `BMCD_ASSERT_SAME(a_no_stall_when_empty, clk, rst_n, !out_valid, !in_stall)

  // A held result stays put.
  `BMCD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                    out_valid && $stable(out_overlap_low) && $stable(out_center_shifted))

endmodule

bind box_motion_change_detector_core bmcd_checker u_bmcd_checker (.*);

@@ dv/box_motion_change_detector_core_tb.sv @@
`timescale 1ns / 1ps

module box_motion_change_detector_core_tb;

  localparam int COORD_BITS  = 14;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int DATA_W      = bmcd_pkg::CFG_DATA_W;
  localparam int HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 240;
  localparam int REPORT_MAX  = 10;
  localparam int EXP_IDX_W   = 6;
  localparam int EXP_DEPTH   = 1 << EXP_IDX_W;

  // index past the last register; the block must ignore it
  localparam logic [bmcd_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef struct packed {
    logic [COORD_BITS-1:0] prev_left;
    logic [COORD_BITS-1:0] prev_top;
    logic [COORD_BITS-1:0] prev_width;
    logic [COORD_BITS-1:0] prev_height;
    logic [COORD_BITS-1:0] cur_left;
    logic [COORD_BITS-1:0] cur_top;
    logic [COORD_BITS-1:0] cur_width;
    logic [COORD_BITS-1:0] cur_height;
  } box_pair_t;

  typedef struct packed {
    logic motion;
    logic low;
    logic shifted;
  } motion_flags_t;

  logic clk;
  logic rst_n;

  logic                  in_valid;
  logic                  in_stall;
  logic [COORD_BITS-1:0] in_prev_left;
  logic [COORD_BITS-1:0] in_prev_top;
  logic [COORD_BITS-1:0] in_prev_width;
  logic [COORD_BITS-1:0] in_prev_height;
  logic [COORD_BITS-1:0] in_cur_left;
  logic [COORD_BITS-1:0] in_cur_top;
  logic [COORD_BITS-1:0] in_cur_width;
  logic [COORD_BITS-1:0] in_cur_height;

  logic out_valid;
  logic out_stall;
  logic out_motion_detected;
  logic out_overlap_low;
  logic out_center_shifted;

  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [bmcd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bmcd_pkg::CFG_DATA_W-1:0] cfg_data;

  // register shadow
  logic                               en_r;
  logic [bmcd_pkg::OVERLAP_THR_W-1:0] ovl_thr_r;
  logic [bmcd_pkg::RATIO_THR_W-1:0]   ratio_thr_r;

  // expected results, written by the sender and read by the checker
  motion_flags_t exp_mem[EXP_DEPTH];
  int            exp_wr_count = 0;
  int            exp_rd_count = 0;
  int            mismatch_count = 0;
  int            cycle_count = 0;
  bit            idle_on;
  bit            hold_req;
  bit            hold_done;

  box_motion_change_detector_core #(
    .COORD_BITS(COORD_BITS)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_prev_left       (in_prev_left),
    .in_prev_top        (in_prev_top),
    .in_prev_width      (in_prev_width),
    .in_prev_height     (in_prev_height),
    .in_cur_left        (in_cur_left),
    .in_cur_top         (in_cur_top),
    .in_cur_width       (in_cur_width),
    .in_cur_height      (in_cur_height),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_motion_detected(out_motion_detected),
    .out_overlap_low    (out_overlap_low),
    .out_center_shifted (out_center_shifted),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint unsigned clip_span(input longint unsigned a0, a1, b0, b1);
    longint unsigned lo;
    longint unsigned hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  function automatic longint unsigned abs_gap(input longint unsigned a, b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic motion_flags_t predict_motion(input box_pair_t b);
    longint unsigned pl, pt, pw, ph, cl, ct, cw, ch;
    longint unsigned iw, ih, inter, area_u, thr, dx, dy, diag2, lhs, r2;
    motion_flags_t   f;
    pl = b.prev_left;  pt = b.prev_top;  pw = b.prev_width; ph = b.prev_height;
    cl = b.cur_left;   ct = b.cur_top;   cw = b.cur_width;  ch = b.cur_height;
    f = '0;
    if (en_r) begin
      iw     = clip_span(pl, pl + pw, cl, cl + cw);
      ih     = clip_span(pt, pt + ph, ct, ct + ch);
      inter  = iw * ih;
      area_u = pw * ph + cw * ch - inter;
      thr    = ovl_thr_r;
      // an empty union reads as IoU zero
      if (area_u == 0) f.low = (thr > 0);
      else             f.low = (inter << bmcd_pkg::OVERLAP_FRAC) < thr * area_u;
      if (!f.low) begin
        dx    = abs_gap(2 * cl + cw, 2 * pl + pw);
        dy    = abs_gap(2 * ct + ch, 2 * pt + ph);
        diag2 = pw * pw + ph * ph;
        if (diag2 != 0) begin
          lhs       = (dx * dx + dy * dy) << bmcd_pkg::SHIFT_SCALE;
          r2        = longint'(ratio_thr_r) * longint'(ratio_thr_r);
          f.shifted = (lhs / diag2) >= r2;
        end
      end
    end
    f.motion = f.low | f.shifted;
    return f;
  endfunction

  function automatic box_pair_t mk_pair(input int pl, pt, pw, ph, cl, ct, cw, ch);
    box_pair_t p;
    p.prev_left  = pl[COORD_BITS-1:0];  p.prev_top    = pt[COORD_BITS-1:0];
    p.prev_width = pw[COORD_BITS-1:0];  p.prev_height = ph[COORD_BITS-1:0];
    p.cur_left   = cl[COORD_BITS-1:0];  p.cur_top     = ct[COORD_BITS-1:0];
    p.cur_width  = cw[COORD_BITS-1:0];  p.cur_height  = ch[COORD_BITS-1:0];
    return p;
  endfunction

  function automatic int nudge(input int v, input int span);
    int d;
    d = int'($urandom_range(0, 2 * span)) - span + v;
    if (d < 0) d = 0;
    if (d > COORD_MAX) d = COORD_MAX;
    return d;
  endfunction

  function automatic int corner_val();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 1;
      2:       return COORD_MAX - 1;
      3:       return COORD_MAX;
      default: return int'($urandom_range(0, COORD_MAX));
    endcase
  endfunction

  // Mostly tracked boxes that drift a little between frames; the rest noise,
  // tiny and degenerate boxes, and corner values.
  function automatic box_pair_t random_pair();
    box_pair_t p;
    int        pw, ph, pl, pt, sx, sy;
    int        kind;
    kind = $urandom_range(0, 9);
    if (kind <= 1) begin
      p = mk_pair($urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
    end else if (kind <= 7) begin
      pw = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 4095);
      ph = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 4095);
      pl = $urandom_range(0, COORD_MAX - pw);
      pt = $urandom_range(0, COORD_MAX - ph);
      sx = pw / $urandom_range(2, 12) + 1;
      sy = ph / $urandom_range(2, 12) + 1;
      p  = mk_pair(pl, pt, pw, ph, nudge(pl, sx), nudge(pt, sy),
                   nudge(pw, pw / 8 + 1), nudge(ph, ph / 8 + 1));
    end else if (kind == 8) begin
      p = mk_pair($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 3),
                  $urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 7),
                  $urandom_range(0, 3), $urandom_range(0, 3));
    end else begin
      p = mk_pair(corner_val(), corner_val(), corner_val(), corner_val(),
                  corner_val(), corner_val(), corner_val(), corner_val());
    end
    return p;
  endfunction

  task automatic send_pair(input box_pair_t p);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_prev_left   <= p.prev_left;
    in_prev_top    <= p.prev_top;
    in_prev_width  <= p.prev_width;
    in_prev_height <= p.prev_height;
    in_cur_left    <= p.cur_left;
    in_cur_top     <= p.cur_top;
    in_cur_width   <= p.cur_width;
    in_cur_height  <= p.cur_height;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_mem[exp_wr_count[EXP_IDX_W-1:0]] = predict_motion(p);
    exp_wr_count++;
  endtask

  // drop valid, let every result drain, then give the pipeline time to empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (exp_wr_count != exp_rd_count) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bmcd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bmcd_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      bmcd_pkg::CFG_MOTION_ENABLE: en_r        = val[0];
      bmcd_pkg::CFG_OVERLAP_THR:   ovl_thr_r   = val[bmcd_pkg::OVERLAP_THR_W-1:0];
      bmcd_pkg::CFG_RATIO_THR:     ratio_thr_r = val[bmcd_pkg::RATIO_THR_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_edge_pairs();
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(mk_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                      COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_pair(mk_pair(100, 100, 50, 50, 100, 100, 50, 50));
    send_pair(mk_pair(0, 0, 10, 10, 100, 100, 10, 10));
    send_pair(mk_pair(0, 0, 10, 10, 10, 0, 10, 10));
    send_pair(mk_pair(500, 500, 0, 0, 500, 500, 0, 0));
    send_pair(mk_pair(1000, 1000, 100, 100, 1020, 1000, 100, 100));
    send_pair(mk_pair(1000, 1000, 100, 100, 1002, 1001, 100, 100));
    send_pair(mk_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, COORD_MAX, COORD_MAX));
    send_pair(mk_pair(200, 200, 400, 400, 300, 300, 100, 100));
    send_pair(mk_pair(50, 50, 0, 80, 50, 50, 0, 80));
  endtask

  task automatic test_register_extremes();
    wait_idle();
    // threshold zero: an empty union no longer reads as low overlap
    write_reg(bmcd_pkg::CFG_OVERLAP_THR, 17'd0);
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(mk_pair(40, 40, 0, 0, 30, 30, 20, 20));
    wait_idle();
    // ratio zero: any box with a diagonal counts as shifted
    write_reg(bmcd_pkg::CFG_RATIO_THR, 17'd0);
    send_pair(mk_pair(300, 300, 60, 40, 300, 300, 60, 40));
    wait_idle();
    write_reg(bmcd_pkg::CFG_RATIO_THR, 17'h1FFFF);
    send_pair(mk_pair(0, 0, 1, 1, 16000, 16000, 1, 1));
    send_pair(mk_pair(0, 0, COORD_MAX, COORD_MAX, 1, 1, COORD_MAX, COORD_MAX));
    wait_idle();
    // IoU of exactly one against a threshold of one passes
    write_reg(bmcd_pkg::CFG_OVERLAP_THR, 17'd65536);
    send_pair(mk_pair(300, 300, 60, 40, 300, 300, 60, 40));
    send_pair(mk_pair(300, 300, 60, 40, 301, 300, 60, 40));
    wait_idle();
    // above one: every nonempty union is low
    write_reg(bmcd_pkg::CFG_OVERLAP_THR, 17'h1FFFF);
    send_pair(mk_pair(300, 300, 60, 40, 300, 300, 60, 40));
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0));
    wait_idle();
    // enable bit low under set upper bits: all flags clear
    write_reg(bmcd_pkg::CFG_MOTION_ENABLE, 17'h1FFFE);
    send_pair(mk_pair(0, 0, 10, 10, 100, 100, 10, 10));
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0));
    wait_idle();
    write_reg(CFG_IDX_UNUSED, 17'h1FFFF);
    write_reg(bmcd_pkg::CFG_MOTION_ENABLE, 17'h00001);
    write_reg(bmcd_pkg::CFG_OVERLAP_THR, bmcd_pkg::OVERLAP_THR_RST);
    write_reg(bmcd_pkg::CFG_RATIO_THR, DATA_W'(bmcd_pkg::RATIO_THR_RST));
    send_pair(mk_pair(1000, 1000, 100, 100, 1020, 1000, 100, 100));
  endtask

  task automatic test_output_backpressure();
    idle_on  = 1'b0;
    hold_req = 1'b1;
    repeat (36) send_pair(random_pair());
  endtask

  task automatic test_random_traffic();
    logic [bmcd_pkg::CFG_DATA_W-1:0] data;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      data    = DATA_W'($urandom_range(0, 17'h1FFFF));
      data[0] = (ph == 3) ? 1'b0 : 1'b1;
      write_reg(bmcd_pkg::CFG_MOTION_ENABLE, data);
      case (ph)
        0:       data = 17'h1FFFF;
        1:       data = 17'd0;
        2:       data = 17'd65536;
        default: data = DATA_W'($urandom_range(0, 1) ? $urandom_range(0, 65536)
                                                     : $urandom_range(16384, 60000));
      endcase
      write_reg(bmcd_pkg::CFG_OVERLAP_THR, data);
      case (ph)
        0:       data = 17'd0;
        1:       data = 17'h0FFFF;
        2:       data = DATA_W'($urandom_range(0, 17'h1FFFF));
        default: data = DATA_W'($urandom_range(0, 2000) | ($urandom_range(0, 1) << 16));
      endcase
      write_reg(bmcd_pkg::CFG_RATIO_THR, data);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // alternate idling and back-to-back stretches, none in the last phase
        if (i % 60 == 0) idle_on = (ph != RAND_PHASES - 1) && ($urandom_range(0, 2) != 0);
        send_pair(random_pair());
      end
    end
  endtask

  // result-side stall: short random bursts, or one long hold on request
  initial begin : stall_gen
    int n;
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    motion_flags_t want;
    motion_flags_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_motion_detected, out_overlap_low, out_center_shifted};
      if (exp_wr_count == exp_rd_count) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result: motion=%b low=%b shifted=%b",
                   got.motion, got.low, got.shifted);
      end else begin
        want = exp_mem[exp_rd_count[EXP_IDX_W-1:0]];
        exp_rd_count++;
        if (got.motion !== want.motion || got.low !== want.low ||
            got.shifted !== want.shifted) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("mismatch: expected motion/low/shifted=%b%b%b, got %b%b%b",
                     want.motion, want.low, want.shifted, got.motion, got.low, got.shifted);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_prev_left   = '0;
    in_prev_top    = '0;
    in_prev_width  = '0;
    in_prev_height = '0;
    in_cur_left    = '0;
    in_cur_top     = '0;
    in_cur_width   = '0;
    in_cur_height  = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    en_r           = bmcd_pkg::MOTION_ENABLE_RST;
    ovl_thr_r      = bmcd_pkg::OVERLAP_THR_RST;
    ratio_thr_r    = bmcd_pkg::RATIO_THR_RST;
    idle_on        = 1'b0;
    hold_req       = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_on = 1'b1;
    test_edge_pairs();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic();

    idle_on = 1'b0;
    wait_idle();
    if (mismatch_count == 0 && exp_wr_count == exp_rd_count)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
